[rtl/pmq_pkg.sv]
`default_nettype none

package pmq_pkg;

    // fixed field widths
    localparam int PAYLOAD_W  = 32;
    localparam int LENGTH_W   = 13;
    localparam int PRIO_REQ_W = 6;
    localparam int OUT_PRIO_W = 5;
    localparam int TOTAL_W    = 12;
    localparam int CFG_W      = 12;
    localparam int STATUS_W   = 2;

    // capacity register reset value
    localparam logic [CFG_W-1:0] CAP_RESET = 12'd2048;

    // command codes
    localparam logic CMD_SEND = 1'b0;
    localparam logic CMD_RECV = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEND,
        S_RHEAD,
        S_RENT,
        S_FIN
    } t_state;

    // entry store port controls
    typedef struct packed {
        logic data_rd;
        logic data_wr;
        logic link_rd;
        logic link_wr;
    } t_entry_ctl;

    // level store port controls
    typedef struct packed {
        logic rd;
        logic head_wr;
        logic tail_wr;
    } t_level_ctl;

endpackage

`default_nettype wire

[rtl/pmq_entry_mem.sv]
`default_nettype none

module pmq_entry_mem import pmq_pkg::*; #(
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic                 i_clk,
    input  wire t_entry_ctl           i_ctl,
    input  wire logic [AW-1:0]        i_data_waddr,
    input  wire logic [AW-1:0]        i_data_raddr,
    input  wire logic [PAYLOAD_W-1:0] i_payload,
    input  wire logic [LENGTH_W-1:0]  i_length,
    output logic      [PAYLOAD_W-1:0] o_payload,
    output logic      [LENGTH_W-1:0]  o_length,
    input  wire logic [AW-1:0]        i_link_waddr,
    input  wire logic [AW-1:0]        i_link_wdata,
    input  wire logic [AW-1:0]        i_link_raddr,
    output logic      [AW-1:0]        o_link
);

    logic [PAYLOAD_W+LENGTH_W-1:0] r_data_mem [DEPTH];
    logic [AW-1:0]                 r_link_mem [DEPTH];
    logic [PAYLOAD_W+LENGTH_W-1:0] r_data_q;
    logic [AW-1:0]                 r_link_q;

    // descriptor array: handle and length
    always_ff @(posedge i_clk) begin
        if (i_ctl.data_wr) begin
            r_data_mem[i_data_waddr] <= {i_payload, i_length};
        end
        if (i_ctl.data_rd) begin
            r_data_q <= r_data_mem[i_data_raddr];
        end
    end

    // link array: level chains and free chain
    always_ff @(posedge i_clk) begin
        if (i_ctl.link_wr) begin
            r_link_mem[i_link_waddr] <= i_link_wdata;
        end
        if (i_ctl.link_rd) begin
            r_link_q <= r_link_mem[i_link_raddr];
        end
    end

    assign o_payload = r_data_q[PAYLOAD_W+LENGTH_W-1:LENGTH_W];
    assign o_length  = r_data_q[LENGTH_W-1:0];
    assign o_link    = r_link_q;

endmodule

`default_nettype wire

[rtl/pmq_level_mem.sv]
`default_nettype none

module pmq_level_mem import pmq_pkg::*; #(
    parameter int LEVELS = 32,
    parameter int EW = 11,
    localparam int PW = $clog2(LEVELS)
) (
    input  wire logic          i_clk,
    input  wire t_level_ctl    i_ctl,
    input  wire logic [PW-1:0] i_raddr,
    input  wire logic [PW-1:0] i_waddr,
    input  wire logic [EW-1:0] i_head,
    input  wire logic [EW-1:0] i_tail,
    output logic      [EW-1:0] o_head,
    output logic      [EW-1:0] o_tail
);

    logic [EW-1:0] r_head_mem [LEVELS];
    logic [EW-1:0] r_tail_mem [LEVELS];
    logic [EW-1:0] r_head_q;
    logic [EW-1:0] r_tail_q;

    // per-level list ends, one shared read address
    always_ff @(posedge i_clk) begin
        if (i_ctl.head_wr) begin
            r_head_mem[i_waddr] <= i_head;
        end
        if (i_ctl.tail_wr) begin
            r_tail_mem[i_waddr] <= i_tail;
        end
        if (i_ctl.rd) begin
            r_head_q <= r_head_mem[i_raddr];
            r_tail_q <= r_tail_mem[i_raddr];
        end
    end

    assign o_head = r_head_q;
    assign o_tail = r_tail_q;

endmodule

`default_nettype wire

[rtl/priority_message_queue.sv]
`default_nettype none

// Channel  Direction  Handshake              Contents
// in       input      i_in_valid / o_in_stall  command, priority, length, handle
// out      output     o_out_valid / i_out_stall status, length, priority, handle,
//                                              total, not_empty, has_room
// cfg      input      i_cfg_valid / o_cfg_ready capacity limit
//
// One item at a time. A send is accepted with level and link reads, then written
// back; a receive does a level read, a descriptor read, then the write-back; a
// rejected item is accepted, then finished. The sequence is set by the
// read-modify-write chain through the level and entry memories, each read registered.
// Synchronous active-low reset clears control state; memories are not cleared.
// A waiting result blocks only the final write-back or finish step of the next item.

module priority_message_queue import pmq_pkg::*; #(
    parameter int PRIORITY_LEVELS = 32,
    parameter int QUEUE_DEPTH     = 2048,
    parameter int MAX_LENGTH      = 4096
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_command,
    input  wire logic [PRIO_REQ_W-1:0] i_priority_req,
    input  wire logic [LENGTH_W-1:0]   i_length,
    input  wire logic [PAYLOAD_W-1:0]  i_payload_handle,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic      [STATUS_W-1:0]   o_status,
    output logic      [LENGTH_W-1:0]   o_out_length,
    output logic      [OUT_PRIO_W-1:0] o_out_priority,
    output logic      [PAYLOAD_W-1:0]  o_out_payload,
    output logic      [TOTAL_W-1:0]    o_message_total,
    output logic                       o_not_empty,
    output logic                       o_has_room,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_W-1:0]      i_cfg_data
);

    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int PW    = $clog2(PRIORITY_LEVELS);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int LW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    t_state r_state, n_state;

    logic [CFG_W-1:0]           r_cap;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           r_fresh;
    logic [AW-1:0]              r_free_head;
    logic [PRIORITY_LEVELS-1:0] r_nonempty;

    // latched item
    logic                       r_cmd;
    logic [PW-1:0]              r_lvl;
    logic [LENGTH_W-1:0]        r_len;
    logic [PAYLOAD_W-1:0]       r_handle;
    logic [STATUS_W-1:0]        r_status;

    // output register
    logic                       r_out_valid;
    logic [STATUS_W-1:0]        r_out_status;
    logic [LENGTH_W-1:0]        r_out_length;
    logic [OUT_PRIO_W-1:0]      r_out_priority;
    logic [PAYLOAD_W-1:0]       r_out_payload;
    logic [TOTAL_W-1:0]         r_out_total;
    logic                       r_out_not_empty;
    logic                       r_out_has_room;

    logic                       w_acc;
    logic                       w_out_free;
    logic                       w_bad;
    logic                       w_full;
    logic                       w_empty;
    logic                       w_fresh_left;
    logic [PW-1:0]              w_top;
    logic [LW-1:0]              w_limit;
    logic [CNT_W-1:0]           w_cnt_next;
    logic [AW-1:0]              w_e;
    logic                       w_load;

    t_entry_ctl                 w_ent_ctl;
    t_level_ctl                 w_lvl_ctl;
    logic [AW-1:0]              w_link_waddr;
    logic [AW-1:0]              w_link_wdata;
    logic [AW-1:0]              w_link_raddr;
    logic [AW-1:0]              w_head_wdata;
    logic [PW-1:0]              w_lvl_raddr;

    logic [PAYLOAD_W-1:0]       w_rd_payload;
    logic [LENGTH_W-1:0]        w_rd_length;
    logic [AW-1:0]              w_rd_link;
    logic [AW-1:0]              w_rd_head;
    logic [AW-1:0]              w_rd_tail;

    // handshakes
    assign w_acc       = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // limit in force and item checks
    always_comb begin
        if (LW'(r_cap) < LW'(QUEUE_DEPTH)) begin
            w_limit = LW'(r_cap);
        end else begin
            w_limit = LW'(QUEUE_DEPTH);
        end
    end

    assign w_bad = (7'(i_priority_req) >= 7'(PRIORITY_LEVELS)) || (i_length == '0) ||
                   (32'(i_length) > 32'(MAX_LENGTH));
    assign w_full       = LW'(r_count) >= w_limit;
    assign w_empty      = (r_count == '0) || (r_nonempty == '0);
    assign w_fresh_left = r_fresh < CNT_W'(QUEUE_DEPTH);
    assign w_e          = w_fresh_left ? AW'(r_fresh) : r_free_head;

    // highest non-empty level
    always_comb begin
        w_top = '0;
        for (int i = 0; i < PRIORITY_LEVELS; i++) begin
            if (r_nonempty[i]) begin
                w_top = PW'(i);
            end
        end
    end

    // count after the current item
    always_comb begin
        case (r_state)
            S_SEND:  w_cnt_next = r_count + CNT_W'(1);
            S_RENT:  w_cnt_next = r_count - CNT_W'(1);
            default: w_cnt_next = r_count;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_command == CMD_SEND) begin
                        n_state = (w_bad || w_full) ? S_FIN : S_SEND;
                    end else begin
                        n_state = w_empty ? S_FIN : S_RHEAD;
                    end
                end
            end
            S_RHEAD: n_state = S_RENT;
            S_SEND, S_RENT, S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory controls and result load
    always_comb begin
        w_ent_ctl    = '0;
        w_lvl_ctl    = '0;
        w_load       = 1'b0;
        w_link_waddr = w_rd_tail;
        w_link_wdata = w_e;
        w_link_raddr = r_free_head;
        w_head_wdata = w_e;
        w_lvl_raddr  = (i_command == CMD_SEND) ? PW'(i_priority_req) : w_top;
        case (r_state)
            S_IDLE: begin
                w_lvl_ctl.rd      = w_acc;
                w_ent_ctl.link_rd = w_acc && (i_command == CMD_SEND);
            end
            S_SEND: begin
                if (w_out_free) begin
                    w_load            = 1'b1;
                    w_ent_ctl.data_wr = 1'b1;
                    w_ent_ctl.link_wr = r_nonempty[r_lvl];
                    w_lvl_ctl.head_wr = !r_nonempty[r_lvl];
                    w_lvl_ctl.tail_wr = 1'b1;
                end
            end
            S_RHEAD: begin
                w_ent_ctl.data_rd = 1'b1;
                w_ent_ctl.link_rd = 1'b1;
                w_link_raddr      = w_rd_head;
            end
            S_RENT: begin
                w_link_waddr = w_rd_head;
                w_link_wdata = r_free_head;
                w_head_wdata = w_rd_link;
                if (w_out_free) begin
                    w_load            = 1'b1;
                    w_ent_ctl.link_wr = 1'b1;
                    w_lvl_ctl.head_wr = (w_rd_head != w_rd_tail);
                end
            end
            S_FIN: begin
                w_load = w_out_free;
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_fresh     <= '0;
            r_free_head <= '0;
            r_nonempty  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (w_load) begin
                r_count <= w_cnt_next;
            end
            // send commit: take entry, mark level
            if (w_load && (r_state == S_SEND)) begin
                r_nonempty[r_lvl] <= 1'b1;
                if (w_fresh_left) begin
                    r_fresh <= r_fresh + CNT_W'(1);
                end else begin
                    r_free_head <= w_rd_link;
                end
            end
            // receive commit: recycle entry, clear level when drained
            if (w_load && (r_state == S_RENT)) begin
                r_free_head <= w_rd_head;
                if (w_rd_head == w_rd_tail) begin
                    r_nonempty[r_lvl] <= 1'b0;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item latch
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cmd    <= i_command;
            r_lvl    <= w_lvl_raddr;
            r_len    <= i_length;
            r_handle <= i_payload_handle;
            if (i_command == CMD_SEND) begin
                r_status <= w_bad ? ST_INVALID : (w_full ? ST_FULL : ST_OK);
            end else begin
                r_status <= w_empty ? ST_EMPTY : ST_OK;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_status    <= r_status;
            r_out_total     <= TOTAL_W'(w_cnt_next);
            r_out_not_empty <= (w_cnt_next != '0);
            r_out_has_room  <= (LW'(w_cnt_next) < w_limit);
            if (r_state == S_RENT) begin
                r_out_length   <= (w_rd_length < r_len) ? w_rd_length : r_len;
                r_out_priority <= OUT_PRIO_W'(r_lvl);
                r_out_payload  <= w_rd_payload;
            end else begin
                r_out_length   <= '0;
                r_out_priority <= '0;
                r_out_payload  <= '0;
            end
        end
    end

    pmq_entry_mem #(
        .DEPTH(QUEUE_DEPTH)
    ) u_entry (
        .i_clk       (i_clk),
        .i_ctl       (w_ent_ctl),
        .i_data_waddr(w_e),
        .i_data_raddr(w_rd_head),
        .i_payload   (r_handle),
        .i_length    (r_len),
        .o_payload   (w_rd_payload),
        .o_length    (w_rd_length),
        .i_link_waddr(w_link_waddr),
        .i_link_wdata(w_link_wdata),
        .i_link_raddr(w_link_raddr),
        .o_link      (w_rd_link)
    );

    pmq_level_mem #(
        .LEVELS(PRIORITY_LEVELS),
        .EW    (AW)
    ) u_level (
        .i_clk  (i_clk),
        .i_ctl  (w_lvl_ctl),
        .i_raddr(w_lvl_raddr),
        .i_waddr(r_lvl),
        .i_head (w_head_wdata),
        .i_tail (w_e),
        .o_head (w_rd_head),
        .o_tail (w_rd_tail)
    );

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_out_length    = r_out_length;
    assign o_out_priority  = r_out_priority;
    assign o_out_payload   = r_out_payload;
    assign o_message_total = r_out_total;
    assign o_not_empty     = r_out_not_empty;
    assign o_has_room      = r_out_has_room;

    // held count never exceeds the store
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_count) <= CNT_W'(QUEUE_DEPTH))
        else $error("message count above depth");

    // fresh pointer never runs past the store
    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= CNT_W'(QUEUE_DEPTH))
        else $error("fresh pointer above depth");

    // level bits agree with the count
    a_level_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_nonempty == '0))
        else $error("level bits disagree with count");

    // an accepted item holds off the next one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second item taken while busy");

    // a receive commit always reports success
    a_recv_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (r_state == S_RENT)) |=>
            (o_out_valid && (o_status == ST_OK) && (r_cmd == CMD_RECV)))
        else $error("receive commit without ok result");

endmodule

`default_nettype wire

[dv/message_queue_checker.sv]
`timescale 1ns / 1ps

// Watches the input, config and output channels of the priority message queue.
// Keeps a linked-list copy of the queue, predicts one result per accepted
// transfer and compares every output transfer against the oldest prediction.
module message_queue_checker import pmq_pkg::*; #(
    parameter int LEVELS  = 32,
    parameter int DEPTH   = 2048,
    parameter int MAX_LEN = 4096
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  wire logic                  i_command,
    input  wire logic [PRIO_REQ_W-1:0] i_priority_req,
    input  wire logic [LENGTH_W-1:0]   i_length,
    input  wire logic [PAYLOAD_W-1:0]  i_payload_handle,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  wire logic [STATUS_W-1:0]   i_status,
    input  wire logic [LENGTH_W-1:0]   i_out_length,
    input  wire logic [OUT_PRIO_W-1:0] i_out_priority,
    input  wire logic [PAYLOAD_W-1:0]  i_out_payload,
    input  wire logic [TOTAL_W-1:0]    i_message_total,
    input  wire logic                  i_not_empty,
    input  wire logic                  i_has_room,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam int SLOT_W = $clog2(DEPTH);

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [LENGTH_W-1:0]   length;
        logic [OUT_PRIO_W-1:0] prio;
        logic [PAYLOAD_W-1:0]  payload;
        logic [TOTAL_W-1:0]    total;
        logic                  not_empty;
        logic                  has_room;
    } t_outcome;

    // shadow descriptor store, threaded into per-level lists
    logic [PAYLOAD_W-1:0] entry_handle [DEPTH];
    logic [LENGTH_W-1:0]  entry_len    [DEPTH];
    logic [SLOT_W-1:0]    entry_next   [DEPTH];
    logic [SLOT_W-1:0]    lvl_first    [LEVELS];
    logic [SLOT_W-1:0]    lvl_last     [LEVELS];
    logic [LEVELS-1:0]    lvl_busy;
    logic [SLOT_W-1:0]    recycle_head;
    int                   unused_from;
    int                   held;
    logic [CFG_W-1:0]     cap_reg;

    t_outcome results_due [$];
    t_outcome oldest;
    int       mismatch_count = 0;

    // one line per mismatch
    task automatic report_mismatch(input string what, input logic [31:0] seen,
                                   input logic [31:0] wanted);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                 $time, what, seen, wanted);
    endtask

    // apply one request to the shadow queue and return the result it gives
    function automatic t_outcome apply_request(input logic cmd,
                                               input logic [PRIO_REQ_W-1:0] prio,
                                               input logic [LENGTH_W-1:0] len,
                                               input logic [PAYLOAD_W-1:0] handle);
        t_outcome          res;
        int                ceiling;
        int                lvl;
        logic [SLOT_W-1:0] slot;
        res = '0;
        ceiling = (int'(cap_reg) < DEPTH) ? int'(cap_reg) : DEPTH;
        if (cmd == CMD_SEND) begin
            // argument checks win over the fill check
            if (prio >= LEVELS || len == 0 || len > MAX_LEN) begin
                res.status = ST_INVALID;
            end else if (held >= ceiling) begin
                res.status = ST_FULL;
            end else begin
                // fresh entries first, then the recycled list
                if (unused_from < DEPTH) begin
                    slot = SLOT_W'(unused_from);
                    unused_from++;
                end else begin
                    slot = recycle_head;
                    recycle_head = entry_next[slot];
                end
                entry_handle[slot] = handle;
                entry_len[slot]    = len;
                entry_next[slot]   = '0;
                if (lvl_busy[prio]) begin
                    entry_next[lvl_last[prio]] = slot;
                end else begin
                    lvl_first[prio] = slot;
                    lvl_busy[prio]  = 1'b1;
                end
                lvl_last[prio] = slot;
                held++;
                res.status = ST_OK;
            end
        end else begin
            if (held == 0 || lvl_busy == '0) begin
                res.status = ST_EMPTY;
            end else begin
                // highest non-empty level, oldest entry of it
                lvl = LEVELS - 1;
                while (lvl > 0 && !lvl_busy[lvl])
                    lvl--;
                slot = lvl_first[lvl];
                res.length  = (entry_len[slot] < len) ? entry_len[slot] : len;
                res.prio    = OUT_PRIO_W'(lvl);
                res.payload = entry_handle[slot];
                if (lvl_last[lvl] == slot)
                    lvl_busy[lvl] = 1'b0;
                else
                    lvl_first[lvl] = entry_next[slot];
                entry_next[slot] = recycle_head;
                recycle_head = slot;
                held--;
                res.status = ST_OK;
            end
        end
        res.total     = TOTAL_W'(held);
        res.not_empty = (held > 0);
        res.has_room  = (held < ceiling);
        return res;
    endfunction

    // results drain before new requests land; config must be written only when idle, which is not enforced here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lvl_busy     = '0;
            recycle_head = '0;
            unused_from  = 0;
            held         = 0;
            cap_reg      = CAP_RESET;
            results_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result with no transfer pending", 32'(i_status), '0);
                end else begin
                    oldest = results_due.pop_front();
                    if (i_status !== oldest.status)
                        report_mismatch("status", 32'(i_status), 32'(oldest.status));
                    if (i_out_length !== oldest.length)
                        report_mismatch("out_length", 32'(i_out_length),
                                        32'(oldest.length));
                    if (i_out_priority !== oldest.prio)
                        report_mismatch("out_priority", 32'(i_out_priority),
                                        32'(oldest.prio));
                    if (i_out_payload !== oldest.payload)
                        report_mismatch("out_payload", i_out_payload, oldest.payload);
                    if (i_message_total !== oldest.total)
                        report_mismatch("message_total", 32'(i_message_total),
                                        32'(oldest.total));
                    if (i_not_empty !== oldest.not_empty)
                        report_mismatch("not_empty", 32'(i_not_empty),
                                        32'(oldest.not_empty));
                    if (i_has_room !== oldest.has_room)
                        report_mismatch("has_room", 32'(i_has_room),
                                        32'(oldest.has_room));
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                cap_reg = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                results_due.push_back(apply_request(i_command, i_priority_req,
                                                    i_length, i_payload_handle));
        end
        o_pending    <= results_due.size();
        o_fail_count <= mismatch_count;
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench import pmq_pkg::*;;

    localparam int LEVELS      = 32;
    localparam int DEPTH       = 2048;
    localparam int MAX_LEN     = 4096;
    localparam int CYCLE_LIMIT = 1_000_000;

    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic                  in_command = CMD_SEND;
    logic [PRIO_REQ_W-1:0] in_prio    = '0;
    logic [LENGTH_W-1:0]   in_length  = '0;
    logic [PAYLOAD_W-1:0]  in_handle  = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [STATUS_W-1:0]   out_status;
    logic [LENGTH_W-1:0]   out_length;
    logic [OUT_PRIO_W-1:0] out_prio;
    logic [PAYLOAD_W-1:0]  out_payload;
    logic [TOTAL_W-1:0]    out_total;
    logic                  out_not_empty;
    logic                  out_has_room;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data   = '0;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int burst_left  = 0;
    int stall_mode  = 0;
    int stall_left  = 0;

    priority_message_queue #(
        .PRIORITY_LEVELS(LEVELS),
        .QUEUE_DEPTH    (DEPTH),
        .MAX_LENGTH     (MAX_LEN)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_command       (in_command),
        .i_priority_req  (in_prio),
        .i_length        (in_length),
        .i_payload_handle(in_handle),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_status        (out_status),
        .o_out_length    (out_length),
        .o_out_priority  (out_prio),
        .o_out_payload   (out_payload),
        .o_message_total (out_total),
        .o_not_empty     (out_not_empty),
        .o_has_room      (out_has_room),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    message_queue_checker #(
        .LEVELS (LEVELS),
        .DEPTH  (DEPTH),
        .MAX_LEN(MAX_LEN)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_command       (in_command),
        .i_priority_req  (in_prio),
        .i_length        (in_length),
        .i_payload_handle(in_handle),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_status        (out_status),
        .i_out_length    (out_length),
        .i_out_priority  (out_prio),
        .i_out_payload   (out_payload),
        .i_message_total (out_total),
        .i_not_empty     (out_not_empty),
        .i_has_room      (out_has_room),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver back-pressure: one of four stall modes, rechosen at random
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 80);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 1) == 1);
            2: out_stall <= ($urandom_range(0, 7) != 0);
            default: out_stall <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // drive one request and hold it until the transfer; bursts with random gaps
    task automatic issue(input logic cmd, input logic [PRIO_REQ_W-1:0] prio,
                         input logic [LENGTH_W-1:0] len, input logic [PAYLOAD_W-1:0] handle);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        in_command <= cmd;
        in_prio    <= prio;
        in_length  <= len;
        in_handle  <= handle;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // hold off until every predicted result has come out
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed sends and receives, some malformed sends
    task automatic random_item(input int hot);
        int                    roll;
        logic [PRIO_REQ_W-1:0] prio;
        logic [LENGTH_W-1:0]   len;
        roll = $urandom_range(0, 99);
        prio = ($urandom_range(0, 1) == 1) ? PRIO_REQ_W'($urandom_range(0, 31))
                                           : PRIO_REQ_W'(hot + $urandom_range(0, 2));
        if (roll < 8) begin
            case ($urandom_range(0, 2))
                0: issue(CMD_SEND, PRIO_REQ_W'($urandom_range(32, 63)),
                         LENGTH_W'($urandom_range(1, 4096)), $urandom);
                1: issue(CMD_SEND, prio, '0, $urandom);
                default: issue(CMD_SEND, prio, LENGTH_W'($urandom_range(4097, 8191)),
                               $urandom);
            endcase
        end else if (roll < 60) begin
            if ($urandom_range(0, 9) == 0)
                len = ($urandom_range(0, 1) == 1) ? 13'd4096 : 13'd1;
            else
                len = LENGTH_W'($urandom_range(1, 4096));
            issue(CMD_SEND, prio, len, $urandom);
        end else begin
            if ($urandom_range(0, 9) == 0)
                len = LENGTH_W'($urandom_range(4097, 8191));
            else
                len = LENGTH_W'($urandom_range(0, 4096));
            issue(CMD_RECV, PRIO_REQ_W'($urandom_range(0, 63)), len, $urandom);
        end
    endtask

    initial begin
        int               i;
        int               phase;
        int               hot_level;
        logic [CFG_W-1:0] lim;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty, field extremes, bad arguments, FIFO order, truncation
        issue(CMD_RECV, 6'd0, 13'd0, 32'h0);
        issue(CMD_SEND, 6'd0, 13'd1, 32'h0);
        issue(CMD_SEND, 6'd31, 13'd4096, 32'hFFFF_FFFF);
        issue(CMD_SEND, 6'd32, 13'd10, 32'h1234_5678);
        issue(CMD_SEND, 6'd63, 13'd8191, 32'h8765_4321);
        issue(CMD_SEND, 6'd7, 13'd0, 32'h0BAD_0001);
        issue(CMD_SEND, 6'd7, 13'd4097, 32'h0BAD_0002);
        issue(CMD_SEND, 6'd5, 13'd100, 32'hA5A5_0001);
        issue(CMD_SEND, 6'd5, 13'd200, 32'hA5A5_0002);
        issue(CMD_RECV, 6'd0, 13'd8191, 32'h0);
        issue(CMD_RECV, 6'd0, 13'd0, 32'h0);
        issue(CMD_RECV, 6'd0, 13'd150, 32'h0);
        issue(CMD_RECV, 6'd0, 13'd4096, 32'h0);
        issue(CMD_RECV, 6'd63, 13'd4096, 32'hFFFF_FFFF);

        // small limit: full, and bad arguments reported ahead of full
        write_limit(12'd3);
        issue(CMD_SEND, 6'd2, 13'd11, 32'hC0DE_0001);
        issue(CMD_SEND, 6'd9, 13'd22, 32'hC0DE_0002);
        issue(CMD_SEND, 6'd2, 13'd33, 32'hC0DE_0003);
        issue(CMD_SEND, 6'd4, 13'd44, 32'hC0DE_0004);
        issue(CMD_SEND, 6'd33, 13'd55, 32'hC0DE_0005);

        // limit lowered under the held count
        write_limit(12'd1);
        issue(CMD_SEND, 6'd1, 13'd66, 32'hC0DE_0006);
        issue(CMD_RECV, 6'd0, 13'd4096, 32'h0);
        issue(CMD_RECV, 6'd0, 13'd4096, 32'h0);
        issue(CMD_RECV, 6'd0, 13'd4096, 32'h0);

        // zero limit
        write_limit(12'd0);
        issue(CMD_SEND, 6'd0, 13'd1, 32'h0);
        issue(CMD_RECV, 6'd0, 13'd1, 32'h0);

        // top register value: a run of sends, then drain one past empty
        write_limit(12'd4095);
        for (i = 0; i < 40; i++)
            issue(CMD_SEND, PRIO_REQ_W'($urandom_range(0, 31)),
                  LENGTH_W'($urandom_range(1, 4096)), $urandom);
        issue(CMD_SEND, 6'd40, 13'd8, $urandom);
        for (i = 0; i <= 40; i++)
            issue(CMD_RECV, PRIO_REQ_W'($urandom_range(0, 63)),
                  LENGTH_W'($urandom_range(0, 8191)), $urandom);

        // random traffic over several limits
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: lim = CAP_RESET;
                1: lim = CFG_W'($urandom_range(1, 8));
                2: lim = 12'd4095;
                3: lim = CFG_W'($urandom_range(0, 4095));
                default: lim = 12'd2;
            endcase
            write_limit(lim);
            hot_level = $urandom_range(0, 29);
            for (i = 0; i < 150; i++) begin
                random_item(hot_level);
                if ($urandom_range(0, 59) == 0)
                    settle();
            end
        end

        settle();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/pmq_pkg.sv
rtl/pmq_entry_mem.sv
rtl/pmq_level_mem.sv
rtl/priority_message_queue.sv
dv/message_queue_checker.sv
dv/testbench.sv
